### hw/rtl/smcs_pkg.sv
// smcs_pkg: shared types and constants of the spi mram command sequencer
// used by smcs_logic, spi_mram_command_sequencer and smcs_checker
package smcs_pkg;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_DONE  = 2'd2,
		OP_POLL  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_DONE  = 2'd0,
		KIND_JOB   = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		CODE_OK       = 3'd0,
		CODE_BAD_CHIP = 3'd1,
		CODE_BUSY     = 3'd2,
		CODE_LENGTH   = 3'd3,
		CODE_ADDRESS  = 3'd4
	} code_t;

	typedef enum logic [3:0] {
		PH_NOT_INIT = 4'd0,
		PH_SR1      = 4'd1,
		PH_SR2      = 4'd2,
		PH_IDLE     = 4'd3,
		PH_RX       = 4'd4,
		PH_WREN     = 4'd5,
		PH_TX       = 4'd6,
		PH_WRDI     = 4'd7,
		PH_ERR_SIG  = 4'd8,
		PH_ERR      = 4'd9
	} phase_t;

	localparam logic [7:0] CMD_STATUS = 8'h05;
	localparam logic [7:0] CMD_READ   = 8'h03;
	localparam logic [7:0] CMD_WREN   = 8'h06;
	localparam logic [7:0] CMD_WRITE  = 8'h02;
	localparam logic [7:0] CMD_WRDI   = 8'h04;

	localparam logic [7:0]  STATUS_MASK  = 8'hFD;
	localparam logic [7:0]  STATUS_CLEAR = 8'hFF;
	localparam logic [18:0] ADDR_LIMIT   = 19'h20000;
	localparam logic [10:0] HDR_LEN      = 11'd4;

	typedef struct packed {
		op_t         op;
		logic [2:0]  chip;
		logic [17:0] address;
		logic [11:0] length;
		logic        job_ok;
		logic [7:0]  status_byte;
	} item_t;

	typedef struct packed {
		phase_t      phase;
		logic        busy;
		logic [16:0] addr;
		logic [10:0] len;
		logic [7:0]  status;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{
		phase: PH_NOT_INIT, busy: 1'b0, addr: '0, len: '0, status: '0};

	typedef struct packed {
		kind_t       kind;
		logic [2:0]  chip;
		code_t       code;
		logic [7:0]  cmd;
		logic [16:0] job_address;
		logic [10:0] tx_length;
		logic [10:0] rx_length;
		logic [17:0] done_address;
		logic [11:0] done_length;
		logic [7:0]  error_status;
	} result_t;

	typedef struct packed {
		logic   we;
		entry_t entry;
	} update_t;

endpackage

### hw/rtl/smcs_logic.sv
// smcs_logic: per-chip phase update and result decode for one word
// depends on smcs_pkg
module smcs_logic #(
	parameter int CHIP_COUNT   = 4,
	parameter int MAX_TRANSFER = 1024
) (
	input  smcs_pkg::item_t   item,
	input  smcs_pkg::entry_t  cur,
	output smcs_pkg::update_t upd,
	output logic              res_valid,
	output smcs_pkg::result_t res
);
	import smcs_pkg::*;

	logic        chip_ok;
	logic [18:0] span;
	code_t       req_code;
	entry_t      nxt;
	logic        we;

	assign chip_ok = {1'b0, item.chip} < 4'(CHIP_COUNT);
	assign span    = 19'(item.address) + 19'(item.length);
	assign upd     = '{we: we, entry: nxt};

	always_comb begin
		if (!chip_ok)
			req_code = CODE_BAD_CHIP;
		else if (cur.phase != PH_IDLE)
			req_code = CODE_BUSY;
		else if (item.length > 12'(MAX_TRANSFER))
			req_code = CODE_LENGTH;
		else if (span > ADDR_LIMIT)
			req_code = CODE_ADDRESS;
		else
			req_code = CODE_OK;
	end

	// next state
	always_comb begin
		nxt = cur;
		we  = 1'b0;
		unique case (item.op) inside
			OP_READ, OP_WRITE: begin
				if (req_code == CODE_OK) begin
					we        = 1'b1;
					nxt.busy  = 1'b1;
					nxt.addr  = item.address[16:0];
					nxt.len   = item.length[10:0];
					nxt.phase = (item.op == OP_WRITE) ? PH_WREN : PH_RX;
				end
			end
			OP_DONE: begin
				if (chip_ok) begin
					we       = 1'b1;
					nxt.busy = 1'b0;
					if (cur.phase == PH_SR1 || cur.phase == PH_SR2)
						nxt.status = item.status_byte;
					if (!item.job_ok)
						nxt.phase = PH_ERR_SIG;
				end
			end
			OP_POLL: begin
				if (chip_ok && !cur.busy) begin
					we = 1'b1;
					unique case (cur.phase) inside
						PH_NOT_INIT, PH_SR1: begin
							nxt.phase  = (cur.phase == PH_NOT_INIT) ? PH_SR1 : PH_SR2;
							nxt.busy   = 1'b1;
							nxt.status = STATUS_CLEAR;
						end
						PH_SR2: begin
							nxt.phase = ((cur.status & STATUS_MASK) != 8'd0) ? PH_ERR : PH_IDLE;
						end
						PH_RX, PH_WRDI: nxt.phase = PH_IDLE;
						PH_WREN: begin
							nxt.phase = PH_TX;
							nxt.busy  = 1'b1;
						end
						PH_TX: begin
							nxt.phase = PH_WRDI;
							nxt.busy  = 1'b1;
						end
						PH_ERR_SIG: nxt.phase = PH_ERR;
						default: we = 1'b0;
					endcase
				end
			end
			default: we = 1'b0;
		endcase
	end

	// outputs
	always_comb begin
		res       = '0;
		res.chip  = item.chip;
		res_valid = 1'b0;
		unique case (item.op) inside
			OP_READ, OP_WRITE: begin
				res_valid = 1'b1;
				if (req_code != CODE_OK) begin
					res.kind         = KIND_DONE;
					res.code         = req_code;
					res.done_address = item.address;
					res.done_length  = item.length;
				end else if (item.op == OP_WRITE) begin
					res.kind      = KIND_JOB;
					res.cmd       = CMD_WREN;
					res.tx_length = 11'd1;
				end else begin
					res.kind        = KIND_JOB;
					res.cmd         = CMD_READ;
					res.job_address = item.address[16:0];
					res.tx_length   = HDR_LEN;
					res.rx_length   = item.length[10:0];
				end
			end
			OP_POLL: begin
				if (chip_ok && !cur.busy) begin
					unique case (cur.phase) inside
						PH_NOT_INIT, PH_SR1: begin
							res_valid     = 1'b1;
							res.kind      = KIND_JOB;
							res.cmd       = CMD_STATUS;
							res.tx_length = 11'd1;
							res.rx_length = 11'd1;
						end
						PH_SR2: begin
							if ((cur.status & STATUS_MASK) != 8'd0) begin
								res_valid        = 1'b1;
								res.kind         = KIND_ERROR;
								res.error_status = cur.status;
							end
						end
						PH_RX, PH_WRDI: begin
							res_valid        = 1'b1;
							res.kind         = KIND_DONE;
							res.done_address = 18'(cur.addr);
							res.done_length  = 12'(cur.len);
						end
						PH_WREN: begin
							res_valid       = 1'b1;
							res.kind        = KIND_JOB;
							res.cmd         = CMD_WRITE;
							res.job_address = cur.addr;
							res.tx_length   = cur.len + HDR_LEN;
						end
						PH_TX: begin
							res_valid     = 1'b1;
							res.kind      = KIND_JOB;
							res.cmd       = CMD_WRDI;
							res.tx_length = 11'd1;
						end
						PH_ERR_SIG: begin
							res_valid = 1'b1;
							res.kind  = KIND_ERROR;
						end
						default: res_valid = 1'b0;
					endcase
				end
			end
			default: res_valid = 1'b0;
		endcase
	end

endmodule

### hw/rtl/spi_mram_command_sequencer.sv
// spi_mram_command_sequencer: top level, per-chip state memory and word pipeline
// depends on smcs_pkg and smcs_logic
//
// input channel (in_valid/in_ready) carries one word: operation, chip, address,
// length, job_ok, status_byte. output channel (out_valid/out_ready) carries at
// most one result word per input word: a completion or rejection, a bus job
// header, or an error event.
// an accepted word reads its chip's entry from the state memory into the read
// register as it is accepted, is decoded in the next cycle and written back when
// it leaves the decode stage; its result is loaded into the output register then.
// a new word is taken every cycle unless the decode stage holds; a write-back to
// the same chip as the word being accepted is forwarded into the read register.
// the output register holds a result until taken; while it is full and not
// taken a word in the decode stage holds and in_ready drops. words without a
// result pass through without touching the output register.
// reset clears the pipeline and the per-chip valid flags, so every chip reads
// as not initialized, not busy, with a zero status byte; no clearing pass.
module spi_mram_command_sequencer #(
	parameter int CHIP_COUNT   = 4,
	parameter int MAX_TRANSFER = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [2:0]  chip,
	input  logic [17:0] address,
	input  logic [11:0] length,
	input  logic        job_ok,
	input  logic [7:0]  status_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic [2:0]  result_chip,
	output logic [2:0]  result_code,
	output logic [7:0]  command_byte,
	output logic [16:0] job_address,
	output logic [10:0] tx_length,
	output logic [10:0] rx_length,
	output logic [17:0] done_address,
	output logic [11:0] done_length,
	output logic [7:0]  error_status
);
	import smcs_pkg::*;

	localparam int CW = (CHIP_COUNT > 1) ? $clog2(CHIP_COUNT) : 1;

	entry_t                mem [CHIP_COUNT];
	logic [CHIP_COUNT-1:0] init_q;

	logic    valid_s1;
	item_t   item_s1;
	entry_t  mem_rd_s1;
	logic    init_s1;
	logic    fwd_s1;
	entry_t  fwd_data_s1;

	logic    out_valid_q;
	result_t out_q;

	logic    in_fire;
	logic    adv;
	logic    wr_en;
	logic    hit;
	entry_t  cur;
	update_t upd;
	logic    res_valid;
	result_t res;
	logic [CW-1:0] rd_idx;
	logic [CW-1:0] wr_idx;

	assign in_fire = in_valid && in_ready;
	assign adv     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign wr_en   = adv && upd.we;
	assign hit     = wr_en && (chip == item_s1.chip);
	assign rd_idx  = chip[CW-1:0];
	assign wr_idx  = item_s1.chip[CW-1:0];
	assign cur     = fwd_s1 ? fwd_data_s1 : (init_s1 ? mem_rd_s1 : ENTRY_RESET);

	smcs_logic #(
		.CHIP_COUNT  (CHIP_COUNT),
		.MAX_TRANSFER(MAX_TRANSFER)
	) u_logic (
		.item     (item_s1),
		.cur      (cur),
		.upd      (upd),
		.res_valid(res_valid),
		.res      (res)
	);

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_idx] <= upd.entry;
		if (in_fire)
			mem_rd_s1 <= mem[rd_idx];
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1     <= '{op: op_t'(operation), chip: chip, address: address,
				length: length, job_ok: job_ok, status_byte: status_byte};
			fwd_data_s1 <= upd.entry;
		end
		if (adv && res_valid)
			out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			init_s1     <= 1'b0;
			fwd_s1      <= 1'b0;
			init_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
				init_s1  <= init_q[rd_idx];
				fwd_s1   <= hit;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (wr_en)
				init_q[wr_idx] <= 1'b1;
			if (adv && res_valid)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = out_q.kind;
	assign result_chip  = out_q.chip;
	assign result_code  = out_q.code;
	assign command_byte = out_q.cmd;
	assign job_address  = out_q.job_address;
	assign tx_length    = out_q.tx_length;
	assign rx_length    = out_q.rx_length;
	assign done_address = out_q.done_address;
	assign done_length  = out_q.done_length;
	assign error_status = out_q.error_status;

endmodule

### hw/rtl/smcs_checker.sv
// smcs_checker: port-level assertions for spi_mram_command_sequencer and its bind
// depends on smcs_pkg
module smcs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  result_kind,
	input logic [2:0]  result_code,
	input logic [7:0]  command_byte,
	input logic [10:0] tx_length,
	input logic [10:0] rx_length,
	input logic [17:0] done_address,
	input logic [11:0] done_length
);
	import smcs_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_rise_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result word without an accepted input word");

	a_job_opcode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_JOB |->
			command_byte == CMD_STATUS || command_byte == CMD_READ ||
			command_byte == CMD_WREN || command_byte == CMD_WRITE ||
			command_byte == CMD_WRDI)
		else $error("bus job with unknown opcode");

	a_nonjob_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind != KIND_JOB |->
			command_byte == 8'd0 && tx_length == 11'd0 && rx_length == 11'd0)
		else $error("job fields set on a non-job result");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_ERROR |->
			result_code == CODE_OK && done_address == 18'd0 && done_length == 12'd0)
		else $error("completion fields set on an error event");

endmodule

bind spi_mram_command_sequencer smcs_checker u_smcs_checker (.*);
